>>> rtl/limit_order_book_matcher_unit_defines.svh
// Assertion macros shared by the order book RTL.
// Expects clk and rst_n in the scope of the module that uses them.
`ifndef LIMIT_ORDER_BOOK_MATCHER_UNIT_DEFINES_SVH
`define LIMIT_ORDER_BOOK_MATCHER_UNIT_DEFINES_SVH

// Same-cycle implication, off while in reset.
`define LOB_CHK_IMPL(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("order book check failed (same cycle)");

// Next-cycle implication, off while in reset.
`define LOB_CHK_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("order book check failed (next cycle)");

`endif

>>> rtl/lob_pkg.sv
// Shared types and codes for the limit order book matcher.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package lob_pkg;

    typedef enum logic [1:0] {
        MODE_ADD    = 2'd0,
        MODE_CANCEL = 2'd1,
        MODE_QUERY  = 2'd2,
        MODE_NOP    = 2'd3
    } mode_t;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
    localparam logic [1:0] STAT_FULL      = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADD_CHK,
        ST_SCAN,
        ST_FILL,
        ST_PLACE,
        ST_REMOVE,
        ST_BEST,
        ST_EMIT_RD,
        ST_EMIT_WR
    } state_t;

    // Per-cycle command broadcast to every cell of the chain.
    typedef struct packed {
        logic rotate;   // every cell takes its neighbor, last takes cell 0
        logic remove;   // cells at or above sel take their neighbor
        logic update;   // cell sel loads a new quantity
        logic append;   // cell at len loads the new order
    } cell_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/lob_cell.sv
// One slot of the order chain: valid, side, price, quantity and id.
// Depends on lob_pkg for the broadcast command struct.
`timescale 1ns / 1ps
`default_nettype none

module lob_cell
    import lob_pkg::*;
#(
    parameter int IDX        = 0,
    parameter int IDX_W      = 6,
    parameter int LEN_W      = 7,
    parameter int PRICE_BITS = 10,
    parameter int QTY_BITS   = 32,
    parameter int ID_BITS    = 32
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire cell_ctrl_t            ctrl,
    input  wire logic [IDX_W-1:0]      sel,
    input  wire logic [LEN_W-1:0]      len,
    input  wire logic [QTY_BITS-1:0]   upd_qty,
    input  wire logic                  new_side,
    input  wire logic [PRICE_BITS-1:0] new_price,
    input  wire logic [QTY_BITS-1:0]   new_qty,
    input  wire logic [ID_BITS-1:0]    new_id,
    input  wire logic                  nbr_valid,
    input  wire logic                  nbr_side,
    input  wire logic [PRICE_BITS-1:0] nbr_price,
    input  wire logic [QTY_BITS-1:0]   nbr_qty,
    input  wire logic [ID_BITS-1:0]    nbr_id,
    output logic                       valid,
    output logic                       side,
    output logic [PRICE_BITS-1:0]      price,
    output logic [QTY_BITS-1:0]        qty,
    output logic [ID_BITS-1:0]         id
);

    logic take_nbr;
    logic hit_sel;
    logic hit_len;

    assign hit_sel  = (IDX_W'(IDX) == sel);
    assign hit_len  = (LEN_W'(IDX) == len);
    assign take_nbr = ctrl.rotate || (ctrl.remove && (IDX_W'(IDX) >= sel));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid <= 1'b0;
        end
        else if (take_nbr)
        begin
            valid <= nbr_valid;
        end
        else if (ctrl.append && hit_len)
        begin
            valid <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_nbr)
        begin
            side  <= nbr_side;
            price <= nbr_price;
            qty   <= nbr_qty;
            id    <= nbr_id;
        end
        else if (ctrl.update && hit_sel)
        begin
            qty <= upd_qty;
        end
        else if (ctrl.append && hit_len)
        begin
            side  <= new_side;
            price <= new_price;
            qty   <= new_qty;
            id    <= new_id;
        end
    end

endmodule

`default_nettype wire

>>> rtl/lob_trade_buf.sv
// Trade buffer: holds the fills of one add until the final bests are known.
// One write port, one registered read port; imports lob_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lob_trade_buf
    import lob_pkg::*;
#(
    parameter int WIDTH = 74,
    parameter int DEPTH = 64,
    parameter int AW    = 6
)
(
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> rtl/limit_order_book_matcher_unit.sv
// Price-time priority limit order book. Resting orders live in a chain of
// MAX_ORDERS cells in arrival order; every search (best price for a fill,
// id for a cancel, level sum for a query, best bid/ask) rotates the whole
// chain once past its head, one slot per cycle. One transaction is worked at a
// time: an add does one chain scan and one fill step per fill, then a last scan
// that finds nothing left to match (skipped when the order is used up or has
// filled MAX_ORDERS times), then a best-price pass, then emits its results one
// by one, each held while the output stalls; cancel and query take one scan and
// one best-price pass. Depends on lob_pkg, lob_cell and lob_trade_buf.
`timescale 1ns / 1ps
`default_nettype none
`include "limit_order_book_matcher_unit_defines.svh"

module limit_order_book_matcher_unit
    import lob_pkg::*;
#(
    parameter int MAX_ORDERS = 64,
    parameter int PRICE_BITS = 10,
    parameter int QTY_BITS   = 32,
    parameter int ID_BITS    = 32
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_stall,
    input  wire logic [1:0]              mode,
    input  wire logic                    side,
    input  wire logic [PRICE_BITS-1:0]   price,
    input  wire logic [QTY_BITS-1:0]     quantity,
    input  wire logic [ID_BITS-1:0]      order_ref,
    output logic                         out_valid,
    input  wire logic                    out_stall,
    output logic                         trade_valid,
    output logic [ID_BITS-1:0]           buy_id,
    output logic [ID_BITS-1:0]           sell_id,
    output logic [PRICE_BITS-1:0]        trade_price,
    output logic [QTY_BITS-1:0]          trade_qty,
    output logic [1:0]                   status,
    output logic [QTY_BITS-1:0]          rested_qty,
    output logic [PRICE_BITS-1:0]        best_bid,
    output logic [PRICE_BITS-1:0]        best_ask,
    output logic [QTY_BITS+6-1:0]        level_volume,
    output logic                         last
);

    localparam int IDX_W    = $clog2(MAX_ORDERS);
    localparam int LEN_W    = $clog2(MAX_ORDERS + 1);
    localparam int VOL_BITS = QTY_BITS + 6;
    localparam int TRD_W    = ID_BITS + PRICE_BITS + QTY_BITS;
    localparam logic [IDX_W-1:0] K_LAST  = IDX_W'(MAX_ORDERS - 1);
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_ORDERS);

    state_t state_reg, state_next;

    logic [IDX_W-1:0]      k_reg;
    logic [1:0]            mode_reg;
    logic                  side_reg;
    logic [PRICE_BITS-1:0] price_reg;
    logic [ID_BITS-1:0]    id_reg;
    logic [QTY_BITS-1:0]   rem_reg;
    logic [LEN_W-1:0]      n_reg;
    logic [LEN_W-1:0]      len_reg;
    logic                  found_reg;
    logic [IDX_W-1:0]      j_reg;
    logic [PRICE_BITS-1:0] bp_reg;
    logic [QTY_BITS-1:0]   bq_reg;
    logic [ID_BITS-1:0]    bid_reg;
    logic [VOL_BITS-1:0]   vol_reg;
    logic [PRICE_BITS-1:0] bb_reg;
    logic [PRICE_BITS-1:0] ba_reg;
    logic                  hb_reg;
    logic                  ha_reg;
    logic [1:0]            status_reg;
    logic [QTY_BITS-1:0]   rested_reg;
    logic [LEN_W-1:0]      r_reg;

    logic                  out_valid_reg;
    logic                  trade_valid_reg;
    logic [ID_BITS-1:0]    buy_id_reg;
    logic [ID_BITS-1:0]    sell_id_reg;
    logic [PRICE_BITS-1:0] trade_price_reg;
    logic [QTY_BITS-1:0]   trade_qty_reg;
    logic [1:0]            out_status_reg;
    logic [QTY_BITS-1:0]   out_rested_reg;
    logic [PRICE_BITS-1:0] best_bid_reg;
    logic [PRICE_BITS-1:0] best_ask_reg;
    logic [VOL_BITS-1:0]   level_volume_reg;
    logic                  last_reg;

    // chain of cells
    logic [MAX_ORDERS-1:0] c_valid;
    logic                  c_side  [MAX_ORDERS];
    logic [PRICE_BITS-1:0] c_price [MAX_ORDERS];
    logic [QTY_BITS-1:0]   c_qty   [MAX_ORDERS];
    logic [ID_BITS-1:0]    c_id    [MAX_ORDERS];
    cell_ctrl_t            cell_ctrl;
    logic [QTY_BITS-1:0]   upd_qty;

    logic                  accept;
    logic                  out_free;
    logic                  k_done;
    logic                  add_hit;
    logic                  cancel_hit;
    logic                  qry_hit;
    logic                  found_now;
    logic [QTY_BITS-1:0]   fill_qty;
    logic                  fill_all;
    logic                  buf_we;
    logic [TRD_W-1:0]      buf_rdata;
    logic                  out_load;
    logic                  any_trade;
    logic [LEN_W-1:0]      last_idx;
    logic                  is_last;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE);
    assign out_free = !out_valid_reg || !out_stall;
    assign k_done   = (k_reg == K_LAST);

    genvar gi;
    generate
        for (gi = 0; gi < MAX_ORDERS; gi++)
        begin : g_cell
            localparam int NB = (gi == MAX_ORDERS - 1) ? 0 : gi + 1;
            logic nb_valid;
            // the tail wraps to the head on rotate, shifts in empty on remove
            assign nb_valid = (gi == MAX_ORDERS - 1) ?
                              (c_valid[0] && cell_ctrl.rotate) : c_valid[NB];
            lob_cell #(
                .IDX        (gi),
                .IDX_W      (IDX_W),
                .LEN_W      (LEN_W),
                .PRICE_BITS (PRICE_BITS),
                .QTY_BITS   (QTY_BITS),
                .ID_BITS    (ID_BITS)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (cell_ctrl),
                .sel       (j_reg),
                .len       (len_reg),
                .upd_qty   (upd_qty),
                .new_side  (side_reg),
                .new_price (price_reg),
                .new_qty   (rem_reg),
                .new_id    (id_reg),
                .nbr_valid (nb_valid),
                .nbr_side  (c_side[NB]),
                .nbr_price (c_price[NB]),
                .nbr_qty   (c_qty[NB]),
                .nbr_id    (c_id[NB]),
                .valid     (c_valid[gi]),
                .side      (c_side[gi]),
                .price     (c_price[gi]),
                .qty       (c_qty[gi]),
                .id        (c_id[gi])
            );
        end
    endgenerate

    // head-of-chain comparisons
    always_comb
    begin
        add_hit = c_valid[0] && (c_side[0] != side_reg)
                  && (side_reg ? (c_price[0] >= price_reg) : (c_price[0] <= price_reg))
                  && (!found_reg || (side_reg ? (c_price[0] > bp_reg)
                                              : (c_price[0] < bp_reg)));
        cancel_hit = c_valid[0] && (c_id[0] == id_reg) && !found_reg;
        qry_hit    = c_valid[0] && (c_side[0] == side_reg) && (c_price[0] == price_reg);
        found_now  = found_reg || ((mode_reg == MODE_ADD) ? add_hit : cancel_hit);
    end

    assign fill_qty = (rem_reg < bq_reg) ? rem_reg : bq_reg;
    assign fill_all = (bq_reg == fill_qty);
    assign upd_qty  = bq_reg - fill_qty;

    assign any_trade = (mode_reg == MODE_ADD) && (n_reg != '0);
    assign last_idx  = any_trade ? (n_reg - LEN_W'(1)) : '0;
    assign is_last   = (r_reg == last_idx);

    lob_trade_buf #(
        .WIDTH (TRD_W),
        .DEPTH (MAX_ORDERS),
        .AW    (IDX_W)
    ) u_trade_buf (
        .clk   (clk),
        .we    (buf_we),
        .waddr (n_reg[IDX_W-1:0]),
        .wdata ({bid_reg, bp_reg, fill_qty}),
        .raddr (r_reg[IDX_W-1:0]),
        .rdata (buf_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (mode == MODE_ADD)
                        state_next = ST_ADD_CHK;
                    else if (mode == MODE_CANCEL || mode == MODE_QUERY)
                        state_next = ST_SCAN;
                    else
                        state_next = ST_BEST;
                end
            end
            ST_ADD_CHK:
                state_next = ((rem_reg != '0) && (n_reg < LEN_MAX)) ? ST_SCAN : ST_PLACE;
            ST_SCAN:
            begin
                if (k_done)
                begin
                    if (mode_reg == MODE_ADD)
                        state_next = found_now ? ST_FILL : ST_PLACE;
                    else if (mode_reg == MODE_CANCEL)
                        state_next = found_now ? ST_REMOVE : ST_BEST;
                    else
                        state_next = ST_BEST;
                end
            end
            ST_FILL:    state_next = ST_ADD_CHK;
            ST_PLACE:   state_next = ST_BEST;
            ST_REMOVE:  state_next = ST_BEST;
            ST_BEST:    state_next = k_done ? ST_EMIT_RD : ST_BEST;
            ST_EMIT_RD: state_next = ST_EMIT_WR;
            ST_EMIT_WR:
            begin
                if (out_free)
                    state_next = is_last ? ST_IDLE : ST_EMIT_RD;
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        cell_ctrl = '0;
        buf_we    = 1'b0;
        out_load  = 1'b0;
        unique case (state_reg)
            ST_SCAN, ST_BEST:
                cell_ctrl.rotate = 1'b1;
            ST_FILL:
            begin
                buf_we           = 1'b1;
                cell_ctrl.remove = fill_all;
                cell_ctrl.update = !fill_all;
            end
            ST_PLACE:
                cell_ctrl.append = (rem_reg != '0) && (len_reg < LEN_MAX);
            ST_REMOVE:
                cell_ctrl.remove = 1'b1;
            ST_EMIT_WR:
                out_load = out_free;
            default:
            begin
                cell_ctrl = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            k_reg         <= '0;
            len_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if ((state_reg == ST_SCAN || state_reg == ST_BEST) && !k_done)
                k_reg <= k_reg + IDX_W'(1);
            else
                k_reg <= '0;
            if ((state_reg == ST_FILL && fill_all) || state_reg == ST_REMOVE)
                len_reg <= len_reg - LEN_W'(1);
            else if (cell_ctrl.append)
                len_reg <= len_reg + LEN_W'(1);
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // transaction datapath
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    mode_reg   <= mode;
                    side_reg   <= side;
                    price_reg  <= price;
                    rem_reg    <= quantity;
                    id_reg     <= order_ref;
                    n_reg      <= '0;
                    r_reg      <= '0;
                    found_reg  <= 1'b0;
                    vol_reg    <= '0;
                    status_reg <= STAT_OK;
                    rested_reg <= '0;
                    hb_reg     <= 1'b0;
                    ha_reg     <= 1'b0;
                    bb_reg     <= '0;
                    ba_reg     <= '0;
                end
            end
            ST_ADD_CHK:
                found_reg <= 1'b0;
            ST_SCAN:
            begin
                if (mode_reg == MODE_ADD && add_hit)
                begin
                    found_reg <= 1'b1;
                    j_reg     <= k_reg;
                    bp_reg    <= c_price[0];
                    bq_reg    <= c_qty[0];
                    bid_reg   <= c_id[0];
                end
                if (mode_reg == MODE_CANCEL && cancel_hit)
                begin
                    found_reg <= 1'b1;
                    j_reg     <= k_reg;
                end
                if (mode_reg == MODE_QUERY && qry_hit)
                    vol_reg <= vol_reg + VOL_BITS'(c_qty[0]);
            end
            ST_FILL:
            begin
                rem_reg <= rem_reg - fill_qty;
                n_reg   <= n_reg + LEN_W'(1);
            end
            ST_PLACE:
            begin
                if (rem_reg != '0)
                begin
                    if (len_reg < LEN_MAX)
                        rested_reg <= rem_reg;
                    else
                        status_reg <= STAT_FULL;
                end
            end
            ST_BEST:
            begin
                if (c_valid[0] && !c_side[0] && (!hb_reg || c_price[0] > bb_reg))
                begin
                    bb_reg <= c_price[0];
                    hb_reg <= 1'b1;
                end
                if (c_valid[0] && c_side[0] && (!ha_reg || c_price[0] < ba_reg))
                begin
                    ba_reg <= c_price[0];
                    ha_reg <= 1'b1;
                end
            end
            ST_EMIT_WR:
            begin
                if (out_load)
                    r_reg <= r_reg + LEN_W'(1);
            end
            default:
            begin
                r_reg <= r_reg;
            end
        endcase
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            trade_valid_reg  <= any_trade;
            trade_price_reg  <= any_trade ? buf_rdata[QTY_BITS +: PRICE_BITS] : '0;
            trade_qty_reg    <= any_trade ? buf_rdata[QTY_BITS-1:0] : '0;
            buy_id_reg       <= !any_trade ? '0 :
                                (side_reg ? buf_rdata[TRD_W-1 -: ID_BITS] : id_reg);
            sell_id_reg      <= !any_trade ? '0 :
                                (side_reg ? id_reg : buf_rdata[TRD_W-1 -: ID_BITS]);
            if (mode_reg == MODE_CANCEL)
                out_status_reg <= found_reg ? STAT_OK : STAT_NOT_FOUND;
            else if (mode_reg == MODE_ADD && is_last)
                out_status_reg <= status_reg;
            else
                out_status_reg <= STAT_OK;
            out_rested_reg   <= (mode_reg == MODE_ADD && is_last) ? rested_reg : '0;
            best_bid_reg     <= bb_reg;
            best_ask_reg     <= ba_reg;
            level_volume_reg <= (mode_reg == MODE_QUERY) ? vol_reg : '0;
            last_reg         <= is_last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign trade_valid  = trade_valid_reg;
    assign buy_id       = buy_id_reg;
    assign sell_id      = sell_id_reg;
    assign trade_price  = trade_price_reg;
    assign trade_qty    = trade_qty_reg;
    assign status       = out_status_reg;
    assign rested_qty   = out_rested_reg;
    assign best_bid     = best_bid_reg;
    assign best_ask     = best_ask_reg;
    assign level_volume = level_volume_reg;
    assign last         = last_reg;

    `LOB_CHK_IMPL(a_len_bound, 1'b1, len_reg <= LEN_MAX)
    `LOB_CHK_IMPL(a_len_matches_cells, 1'b1, $countones(c_valid) == len_reg)
    `LOB_CHK_IMPL(a_fill_has_best, state_reg == ST_FILL, found_reg)
    `LOB_CHK_NEXT(a_accept_leaves_idle, in_valid && !in_stall, state_reg != ST_IDLE)

endmodule

`default_nettype wire

>>> tb/lob_book_checker.sv
// Watches both channels of the order book matcher, keeps its own copy of the book,
// and compares each returned transaction with the oldest predicted one.
// Depends on lob_pkg for the mode and status codes.
`timescale 1ns / 1ps

module lob_book_checker
    import lob_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [1:0]  mode,
    input  logic        side,
    input  logic [9:0]  price,
    input  logic [31:0] quantity,
    input  logic [31:0] order_ref,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic        trade_valid,
    input  logic [31:0] buy_id,
    input  logic [31:0] sell_id,
    input  logic [9:0]  trade_price,
    input  logic [31:0] trade_qty,
    input  logic [1:0]  status,
    input  logic [31:0] rested_qty,
    input  logic [9:0]  best_bid,
    input  logic [9:0]  best_ask,
    input  logic [37:0] level_volume,
    input  logic        last,
    output int          n_errors,
    output int          n_pending
);

    localparam int DEPTH = 64;

    typedef struct packed {
        logic        trade_valid;
        logic [31:0] buy_id;
        logic [31:0] sell_id;
        logic [9:0]  trade_price;
        logic [31:0] trade_qty;
        logic [1:0]  status;
        logic [31:0] rested_qty;
        logic [9:0]  best_bid;
        logic [9:0]  best_ask;
        logic [37:0] level_volume;
        logic        last;
    } book_result_t;

    logic        ord_side  [DEPTH];
    logic [9:0]  ord_price [DEPTH];
    logic [31:0] ord_qty   [DEPTH];
    logic [31:0] ord_id    [DEPTH];
    int          book_len;

    book_result_t expected_results[$];

    // Close the gap left by the order at position j.
    function automatic void close_gap(int j);
        for (int i = j; i + 1 < book_len; i++)
        begin
            ord_side[i]  = ord_side[i+1];
            ord_price[i] = ord_price[i+1];
            ord_qty[i]   = ord_qty[i+1];
            ord_id[i]    = ord_id[i+1];
        end
        book_len--;
    endfunction

    function automatic void match_order(logic [1:0] op, logic sd, logic [9:0] px,
                                        logic [31:0] qty, logic [31:0] id);
        book_result_t res[$];
        book_result_t r;
        logic [31:0]  remaining;
        logic [31:0]  fill;
        logic [9:0]   bid_px;
        logic [9:0]   ask_px;
        logic         has_bid;
        logic         has_ask;
        logic         found;
        int           best;
        r = '0;
        case (mode_t'(op))
            MODE_ADD:
            begin
                remaining = qty;
                while (remaining != 0 && res.size() < DEPTH)
                begin
                    found = 1'b0;
                    best = 0;
                    for (int i = 0; i < book_len; i++)
                    begin
                        if (ord_side[i] == sd)
                            continue;
                        if (sd == 1'b0 ? ord_price[i] > px : ord_price[i] < px)
                            continue;
                        if (!found || (sd == 1'b0 ? ord_price[i] < ord_price[best]
                                                  : ord_price[i] > ord_price[best]))
                        begin
                            found = 1'b1;
                            best = i;
                        end
                    end
                    if (!found)
                        break;
                    fill = (remaining < ord_qty[best]) ? remaining : ord_qty[best];
                    r = '0;
                    r.trade_valid = 1'b1;
                    r.buy_id      = sd ? ord_id[best] : id;
                    r.sell_id     = sd ? id : ord_id[best];
                    r.trade_price = ord_price[best];
                    r.trade_qty   = fill;
                    res = {res, r};
                    remaining      -= fill;
                    ord_qty[best]  -= fill;
                    if (ord_qty[best] == 0)
                        close_gap(best);
                end
                r = '0;
                if (res.size() == 0)
                    res = {res, r};
                if (remaining != 0)
                begin
                    if (book_len < DEPTH)
                    begin
                        ord_side[book_len]  = sd;
                        ord_price[book_len] = px;
                        ord_qty[book_len]   = remaining;
                        ord_id[book_len]    = id;
                        book_len++;
                        res[res.size()-1].rested_qty = remaining;
                    end
                    else
                        res[res.size()-1].status = STAT_FULL;
                end
            end
            MODE_CANCEL:
            begin
                r.status = STAT_NOT_FOUND;
                for (int i = 0; i < book_len; i++)
                    if (ord_id[i] == id)
                    begin
                        close_gap(i);
                        r.status = STAT_OK;
                        break;
                    end
                res = {res, r};
            end
            MODE_QUERY:
            begin
                for (int i = 0; i < book_len; i++)
                    if (ord_side[i] == sd && ord_price[i] == px)
                        r.level_volume += 38'(ord_qty[i]);
                res = {res, r};
            end
            default:
                res = {res, r};
        endcase
        has_bid = 1'b0;
        has_ask = 1'b0;
        bid_px = '0;
        ask_px = '0;
        for (int i = 0; i < book_len; i++)
        begin
            if (ord_side[i] == 1'b0)
            begin
                if (!has_bid || ord_price[i] > bid_px)
                begin
                    bid_px = ord_price[i];
                    has_bid = 1'b1;
                end
            end
            else if (!has_ask || ord_price[i] < ask_px)
            begin
                ask_px = ord_price[i];
                has_ask = 1'b1;
            end
        end
        foreach (res[k])
        begin
            res[k].best_bid = bid_px;
            res[k].best_ask = ask_px;
            res[k].last = (k == res.size() - 1);
            expected_results = {expected_results, res[k]};
        end
    endfunction

    book_result_t seen;
    assign seen = '{trade_valid, buy_id, sell_id, trade_price, trade_qty, status,
                    rested_qty, best_bid, best_ask, level_volume, last};

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            book_len = 0;
            n_errors = 0;
            n_pending = 0;
            expected_results.delete();
        end
        else
        begin
            if (in_valid && !in_stall)
                match_order(mode, side, price, quantity, order_ref);
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("%0t: unexpected result transaction %h", $time, seen);
                end
                else
                begin
                    book_result_t exp_r;
                    exp_r = expected_results.pop_front();
                    if (seen !== exp_r)
                    begin
                        n_errors++;
                        if (n_errors <= 10)
                        begin
                            $display("%0t: result mismatch", $time);
                            $display("  fields tv,buy,sell,px,qty,st,rest,bb,ba,vol,last");
                            $display("  exp %0d %h %h %0d %0d %0d %0d %0d %0d %0d %0d",
                                     exp_r.trade_valid, exp_r.buy_id, exp_r.sell_id,
                                     exp_r.trade_price, exp_r.trade_qty, exp_r.status,
                                     exp_r.rested_qty, exp_r.best_bid, exp_r.best_ask,
                                     exp_r.level_volume, exp_r.last);
                            $display("  got %0d %h %h %0d %0d %0d %0d %0d %0d %0d %0d",
                                     seen.trade_valid, seen.buy_id, seen.sell_id,
                                     seen.trade_price, seen.trade_qty, seen.status,
                                     seen.rested_qty, seen.best_bid, seen.best_ask,
                                     seen.level_volume, seen.last);
                        end
                    end
                end
            end
            n_pending = expected_results.size();
        end
    end

endmodule

>>> tb/tb.sv
// Stimulus and verdict for the order book matcher: directed orders, then random
// order flow with book build-up and sweeps. Depends on lob_pkg and lob_book_checker.
`timescale 1ns / 1ps

module tb;
    import lob_pkg::*;

    localparam int IDLE_LIMIT = 40000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  mode = MODE_NOP;
    logic        side = 1'b0;
    logic [9:0]  price = '0;
    logic [31:0] quantity = '0;
    logic [31:0] order_ref = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        trade_valid;
    logic [31:0] buy_id;
    logic [31:0] sell_id;
    logic [9:0]  trade_price;
    logic [31:0] trade_qty;
    logic [1:0]  status;
    logic [31:0] rested_qty;
    logic [9:0]  best_bid;
    logic [9:0]  best_ask;
    logic [37:0] level_volume;
    logic        last;
    int          n_errors;
    int          n_pending;
    int          idle_pct = 0;
    int          stall_pct = 0;
    int          quiet_cycles = 0;
    logic [31:0] live_ids[$];

    always #5 clk = ~clk;

    limit_order_book_matcher_unit i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .mode(mode), .side(side), .price(price), .quantity(quantity),
        .order_ref(order_ref),
        .out_valid(out_valid), .out_stall(out_stall),
        .trade_valid(trade_valid), .buy_id(buy_id), .sell_id(sell_id),
        .trade_price(trade_price), .trade_qty(trade_qty), .status(status),
        .rested_qty(rested_qty), .best_bid(best_bid), .best_ask(best_ask),
        .level_volume(level_volume), .last(last)
    );

    lob_book_checker i_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .mode(mode), .side(side), .price(price), .quantity(quantity),
        .order_ref(order_ref),
        .out_valid(out_valid), .out_stall(out_stall),
        .trade_valid(trade_valid), .buy_id(buy_id), .sell_id(sell_id),
        .trade_price(trade_price), .trade_qty(trade_qty), .status(status),
        .rested_qty(rested_qty), .best_bid(best_bid), .best_ask(best_ask),
        .level_volume(level_volume), .last(last),
        .n_errors(n_errors), .n_pending(n_pending)
    );

    always @(negedge clk)
        out_stall <= ($urandom_range(99) < stall_pct);

    // Trip when neither channel moves for too long.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("** limit_order_book_matcher_unit: FAILED **");
            $finish;
        end
    end

    task automatic send_order(logic [1:0] op, logic sd, logic [9:0] px,
                              logic [31:0] qty, logic [31:0] id);
        while ($urandom_range(99) < idle_pct)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid  <= 1'b1;
        mode      <= op;
        side      <= sd;
        price     <= px;
        quantity  <= qty;
        order_ref <= id;
        do
            @(posedge clk);
        while (!(in_valid && !in_stall));
        if (op == MODE_ADD)
            live_ids = {live_ids, id};
    endtask

    task automatic drain_book_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (n_pending != 0)
            @(posedge clk);
    endtask

    task automatic random_order();
        int          pick;
        logic [31:0] id;
        logic [31:0] qty;
        logic [9:0]  px;
        pick = $urandom_range(99);
        px = ($urandom_range(9) == 0) ? 10'($urandom) : 10'($urandom_range(520, 480));
        qty = ($urandom_range(9) == 0) ? $urandom : $urandom_range(100, 1);
        if (pick < 55)
            send_order(MODE_ADD, 1'($urandom), px, qty, $urandom);
        else if (pick < 75)
        begin
            if (live_ids.size() != 0 && $urandom_range(9) < 7)
                id = live_ids[$urandom_range(live_ids.size() - 1)];
            else
                id = $urandom;
            send_order(MODE_CANCEL, 1'($urandom), px, qty, id);
        end
        else if (pick < 92)
            send_order(MODE_QUERY, 1'($urandom), px, qty, $urandom);
        else if (pick < 96)
            send_order(MODE_NOP, 1'($urandom), px, qty, $urandom);
        else
            send_order(2'($urandom), 1'($urandom), 10'($urandom), $urandom, $urandom);
    endtask

    // Rest enough passive buys to fill the book, then sweep it with one sell.
    task automatic fill_and_sweep();
        for (int k = 0; k < 70; k++)
            send_order(MODE_ADD, 1'b0, 10'($urandom_range(200, 100)),
                       $urandom_range(50, 1), $urandom);
        send_order(MODE_QUERY, 1'b0, 10'd150, '0, '0);
        send_order(MODE_ADD, 1'b1, 10'd0, 32'hFFFF_FFFF, $urandom);
    endtask

    initial
    begin
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // directed
        send_order(MODE_QUERY, 1'b0, 10'd0, '0, '0);
        send_order(MODE_CANCEL, 1'b1, 10'd0, '0, 32'h1234_5678);
        send_order(MODE_NOP, 1'b1, 10'h3FF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_order(MODE_ADD, 1'b0, 10'd300, 32'd0, 32'd9);
        send_order(MODE_ADD, 1'b0, 10'd0, 32'd5, 32'd1);
        send_order(MODE_ADD, 1'b0, 10'h3FF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_order(MODE_ADD, 1'b1, 10'h3FF, 32'd10, 32'd2);
        send_order(MODE_ADD, 1'b1, 10'd0, 32'd3, 32'd3);
        send_order(MODE_QUERY, 1'b0, 10'h3FF, '0, '0);
        send_order(MODE_CANCEL, 1'b0, 10'd0, '0, 32'hFFFF_FFFF);
        send_order(MODE_ADD, 1'b1, 10'd500, 32'd7, 32'd4);
        send_order(MODE_ADD, 1'b1, 10'd500, 32'd9, 32'd5);
        send_order(MODE_ADD, 1'b1, 10'd400, 32'd2, 32'd6);
        send_order(MODE_QUERY, 1'b1, 10'd500, '0, '0);
        send_order(MODE_ADD, 1'b0, 10'd600, 32'd12, 32'd7);
        send_order(MODE_QUERY, 1'b1, 10'd500, '0, '0);
        send_order(MODE_ADD, 1'b0, 10'd10, 32'd4, 32'd5);
        send_order(MODE_CANCEL, 1'b0, 10'd0, '0, 32'd5);
        send_order(MODE_CANCEL, 1'b0, 10'd0, '0, 32'd5);
        send_order(MODE_ADD, 1'b0, 10'd0, 32'd1, 32'd0);
        send_order(MODE_ADD, 1'b1, 10'd0, 32'd8, 32'd0);

        // random, across idling phases
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 69; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 69; end
                default: begin idle_pct = 8; stall_pct = 8; end
            endcase
            for (int k = 0; k < 25; k++)
                random_order();
            if (ph == 1)
                drain_book_results();
            if (ph == 0 || ph == 3)
                fill_and_sweep();
        end

        drain_book_results();
        repeat (300) @(posedge clk);
        if (n_errors == 0 && n_pending == 0)
            $display("** limit_order_book_matcher_unit: PASSED **");
        else
            $display("** limit_order_book_matcher_unit: FAILED **");
        $finish;
    end

endmodule
